### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the address space mapper.
// Depends on nothing; users provide aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_PROP(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define CHK_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CHK_PROP(lbl, prop)
`define CHK_NEVER(lbl, cond)
`endif
`endif

### rtl/core/gasm_pkg.sv
// Types and constants of the GPU address space mapper.
// Depends on nothing.
package gasm_pkg;
    localparam int ADDR_BITS        = 40;
    localparam int DEF_TABLE_ENTRIES = 32;
    localparam logic [39:0] ALIGN64K = 40'hFFFF;
    localparam logic [32:0] ALIGN4K  = 33'hFFF;
    localparam logic [17:0] DEFAULT_PAGE = 18'd4096;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_MAP    = 2'd1,
        FUNC_UNMAP  = 2'd2,
        FUNC_LOOKUP = 2'd3
    } func_t;

    typedef struct packed {
        logic [39:0] base;
        logic [32:0] bytes;
        logic [63:0] guest;
        logic [31:0] handle;
        logic [31:0] flags;
        logic [17:0] page;
    } entry_t;
endpackage

### rtl/core/gpu_address_space_mapper.sv
// Top level of the GPU address space mapper: bump allocator plus range table.
// Depends on gasm_pkg and assert_macros.svh.
//
// channel | signals                      | accepted when
// s_      | s_valid/s_ready + fields     | s_valid && s_ready
// m_      | m_valid/m_ready + fields     | m_valid && m_ready
// apb     | psel/penable/pwrite/paddr    | psel && penable && pwrite
//
// Alloc goes from idle straight to the result state. Map, unmap and lookup first
// scan the table memory one entry per cycle (one read port), then give the result.
// Reset clears valid bits and the bump pointer; table memory is not cleared.
// A stalled result holds the block before the write-back cycle.
`include "assert_macros.svh"
module gpu_address_space_mapper
    import gasm_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [19:0] s_page_count,
    input  logic [17:0] s_page_bytes,
    input  logic [39:0] s_fixed_addr,
    input  logic [31:0] s_buffer_handle,
    input  logic [31:0] s_map_flag_bits,
    input  logic        s_buffer_found,
    input  logic [31:0] s_buffer_bytes,
    input  logic [63:0] s_buffer_guest_addr,
    input  logic [39:0] s_query_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [39:0] m_gpu_addr,
    output logic        m_ok,
    output logic [63:0] m_guest_addr,
    output logic [32:0] m_entry_size,
    output logic [31:0] m_entry_handle,
    output logic [31:0] m_entry_flags,
    output logic [17:0] m_entry_page_bytes
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

    state_t              state_reg;
    logic [39:0]         va_reg;
    logic [39:0]         bump_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CW-1:0]       cnt_reg;

    func_t               func_reg;
    logic [39:0]         addr_reg;
    logic                fixed_reg;
    logic [37:0]         size_reg;
    logic                found_reg;
    logic [39:0]         q_reg;
    entry_t              new_reg;

    logic                hit_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic                free_reg;
    logic [IW-1:0]       free_idx_reg;
    entry_t              best_reg;

    logic                m_valid_reg;
    logic [39:0]         o_addr_reg;
    logic                o_ok_reg;
    logic [63:0]         o_guest_reg;
    logic [32:0]         o_size_reg;
    logic [31:0]         o_handle_reg;
    logic [31:0]         o_flags_reg;
    logic [17:0]         o_page_reg;

    entry_t              mem [TABLE_ENTRIES];
    entry_t              mem_q;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;

    logic [17:0]         psize;
    logic [39:0]         pick_addr;
    logic [IW-1:0]       jdx;
    logic                jvalid;
    logic [39:0]         diff;
    logic                lk_hit;
    logic [40:0]         bump_sum;
    logic                map_ok;
    logic                out_free;

    assign pready  = 1'b1;
    assign prdata  = {24'b0, va_reg};
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_gpu_addr = o_addr_reg;
    assign m_ok = o_ok_reg;
    assign m_guest_addr = o_guest_reg;
    assign m_entry_size = o_size_reg;
    assign m_entry_handle = o_handle_reg;
    assign m_entry_flags = o_flags_reg;
    assign m_entry_page_bytes = o_page_reg;

    assign psize     = (s_page_bytes == 18'd0) ? DEFAULT_PAGE : s_page_bytes;
    assign pick_addr = (s_fixed_addr != 40'd0) ? s_fixed_addr
                                               : ((va_reg & ~ALIGN64K) + bump_reg);
    assign jdx       = IW'(cnt_reg - CW'(1));
    assign jvalid    = valid_reg[jdx];
    assign diff      = q_reg - best_reg.base;
    assign lk_hit    = hit_reg && (diff < {7'b0, best_reg.bytes});
    assign bump_sum  = {1'b0, bump_reg} + {3'b0, size_reg} + {1'b0, ALIGN64K};
    assign map_ok    = found_reg && (hit_reg || free_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign mem_we    = (state_reg == ST_FIN) && out_free
                       && (func_reg == FUNC_MAP) && map_ok;
    assign mem_wa    = hit_reg ? hit_idx_reg : free_idx_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= new_reg;
        end
        mem_q <= mem[cnt_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            va_reg      <= 40'd0;
            bump_reg    <= 40'd0;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && !paddr[3]) begin
                va_reg <= pwdata[39:0];
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= func_t'(s_func);
                        addr_reg  <= pick_addr;
                        fixed_reg <= (s_fixed_addr != 40'd0);
                        found_reg <= s_buffer_found;
                        q_reg     <= s_query_addr;
                        if (func_t'(s_func) == FUNC_ALLOC) begin
                            size_reg <= s_page_count * psize;
                        end else begin
                            size_reg <= {5'b0, ({1'b0, s_buffer_bytes} + ALIGN4K)
                                               & ~ALIGN4K};
                        end
                        new_reg.base   <= pick_addr;
                        new_reg.bytes  <= ({1'b0, s_buffer_bytes} + ALIGN4K) & ~ALIGN4K;
                        new_reg.guest  <= s_buffer_guest_addr;
                        new_reg.handle <= s_buffer_handle;
                        new_reg.flags  <= s_map_flag_bits;
                        new_reg.page   <= psize;
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                        cnt_reg  <= '0;
                        state_reg <= (func_t'(s_func) == FUNC_ALLOC) ? ST_FIN : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cnt_reg != '0) begin
                        case (func_reg)
                            FUNC_MAP: begin
                                if (jvalid && mem_q.base == addr_reg && !hit_reg) begin
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= jdx;
                                end
                                if (!jvalid && !free_reg) begin
                                    free_reg     <= 1'b1;
                                    free_idx_reg <= jdx;
                                end
                            end
                            FUNC_UNMAP: begin
                                if (jvalid && mem_q.base == q_reg && !hit_reg) begin
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= jdx;
                                end
                            end
                            default: begin
                                if (jvalid && mem_q.base <= q_reg
                                    && (!hit_reg || mem_q.base > best_reg.base)) begin
                                    hit_reg  <= 1'b1;
                                    best_reg <= mem_q;
                                end
                            end
                        endcase
                    end
                    if (cnt_reg == CW'(TABLE_ENTRIES)) begin
                        state_reg <= ST_FIN;
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        o_addr_reg   <= 40'd0;
                        o_ok_reg     <= 1'b0;
                        o_guest_reg  <= 64'd0;
                        o_size_reg   <= 33'd0;
                        o_handle_reg <= 32'd0;
                        o_flags_reg  <= 32'd0;
                        o_page_reg   <= 18'd0;
                        case (func_reg)
                            FUNC_ALLOC: begin
                                o_addr_reg <= addr_reg;
                                o_ok_reg   <= 1'b1;
                                if (!fixed_reg) begin
                                    bump_reg <= {bump_sum[39:16], 16'b0};
                                end
                            end
                            FUNC_MAP: begin
                                if (map_ok) begin
                                    o_addr_reg <= addr_reg;
                                    o_ok_reg   <= 1'b1;
                                    valid_reg[mem_wa] <= 1'b1;
                                    if (!fixed_reg) begin
                                        bump_reg <= {bump_sum[39:16], 16'b0};
                                    end
                                end
                            end
                            FUNC_UNMAP: begin
                                if (hit_reg) begin
                                    o_ok_reg <= 1'b1;
                                    valid_reg[hit_idx_reg] <= 1'b0;
                                end
                            end
                            default: begin
                                if (lk_hit) begin
                                    o_addr_reg   <= best_reg.base;
                                    o_ok_reg     <= 1'b1;
                                    o_guest_reg  <= best_reg.guest + {24'b0, diff};
                                    o_size_reg   <= best_reg.bytes;
                                    o_handle_reg <= best_reg.handle;
                                    o_flags_reg  <= best_reg.flags;
                                    o_page_reg   <= best_reg.page;
                                end
                            end
                        endcase
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `CHK_PROP(a_fail_zero, (m_valid_reg && !o_ok_reg) |-> (o_addr_reg == 40'd0 && o_guest_reg == 64'd0))
    `CHK_PROP(a_busy_after_beat, (s_valid && s_ready) |=> (state_reg != ST_IDLE))
    `CHK_NEVER(a_write_outside_fin, mem_we && (state_reg != ST_FIN))
endmodule

### sim/tb.sv
// Self-checking testbench for gpu_address_space_mapper: directed and random
// alloc/map/unmap/lookup beats checked against an in-bench predictor.
// Depends on gasm_pkg and the RTL of the mapper.
module tb
    import gasm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] REG_VA_REGION_START = 4'd0;
    localparam int         NUM_SLOTS = 32;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         DRAIN_CYCLES = 48;

    typedef struct packed {
        func_t       func;
        logic [19:0] pages;
        logic [17:0] pbytes;
        logic [39:0] fixed;
        logic [31:0] handle;
        logic [31:0] flags;
        logic        found;
        logic [31:0] bbytes;
        logic [63:0] gaddr;
        logic [39:0] query;
    } op_t;

    typedef struct packed {
        logic [39:0] gpu_addr;
        logic        ok;
        logic [63:0] guest;
        logic [32:0] size;
        logic [31:0] handle;
        logic [31:0] flags;
        logic [17:0] page;
    } xlat_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [19:0] s_page_count = '0;
    logic [17:0] s_page_bytes = '0;
    logic [39:0] s_fixed_addr = '0;
    logic [31:0] s_buffer_handle = '0;
    logic [31:0] s_map_flag_bits = '0;
    logic        s_buffer_found = 0;
    logic [31:0] s_buffer_bytes = '0;
    logic [63:0] s_buffer_guest_addr = '0;
    logic [39:0] s_query_addr = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [39:0] m_gpu_addr;
    logic        m_ok;
    logic [63:0] m_guest_addr;
    logic [32:0] m_entry_size;
    logic [31:0] m_entry_handle;
    logic [31:0] m_entry_flags;
    logic [17:0] m_entry_page_bytes;

    gpu_address_space_mapper DUT (.*);

    // predictor state
    logic [39:0] va_start;
    logic [39:0] bump_ofs;
    logic        slot_valid [NUM_SLOTS];
    logic [39:0] slot_base  [NUM_SLOTS];
    logic [32:0] slot_bytes [NUM_SLOTS];
    logic [63:0] slot_guest [NUM_SLOTS];
    logic [31:0] slot_handle[NUM_SLOTS];
    logic [31:0] slot_flags [NUM_SLOTS];
    logic [17:0] slot_page  [NUM_SLOTS];
    logic [39:0] last_mapped;

    xlat_t pending_xlats[$];
    int    errors = 0;
    int    cycles = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_left = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    task automatic predict_mapper(input op_t op, output xlat_t r);
        logic [63:0] psize, size, tmp;
        logic [39:0] a, off;
        int slot, best;
        r = '0;
        slot = -1;
        best = -1;
        psize = (op.pbytes == 0) ? {46'b0, DEFAULT_PAGE} : {46'b0, op.pbytes};
        case (op.func)
            FUNC_ALLOC: begin
                size = {44'b0, op.pages} * psize;
                a = op.fixed;
                if (a == 0) begin
                    a = {va_start[39:16], 16'b0} + bump_ofs;
                    tmp = {24'b0, bump_ofs} + size + 64'hFFFF;
                    bump_ofs = {tmp[39:16], 16'b0};
                end
                r.gpu_addr = a;
                r.ok = 1;
            end
            FUNC_MAP: begin
                if (op.found) begin
                    size = ({32'b0, op.bbytes} + 64'hFFF) & ~64'hFFF;
                    a = op.fixed;
                    if (a == 0)
                        a = {va_start[39:16], 16'b0} + bump_ofs;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (slot < 0 && slot_valid[i] && slot_base[i] == a)
                            slot = i;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (slot < 0 && !slot_valid[i])
                            slot = i;
                    if (slot >= 0) begin
                        if (op.fixed == 0) begin
                            tmp = {24'b0, bump_ofs} + size + 64'hFFFF;
                            bump_ofs = {tmp[39:16], 16'b0};
                        end
                        slot_valid[slot]  = 1;
                        slot_base[slot]   = a;
                        slot_bytes[slot]  = size[32:0];
                        slot_guest[slot]  = op.gaddr;
                        slot_handle[slot] = op.handle;
                        slot_flags[slot]  = op.flags;
                        slot_page[slot]   = psize[17:0];
                        last_mapped = a;
                        r.gpu_addr = a;
                        r.ok = 1;
                    end
                end
            end
            FUNC_UNMAP: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (!r.ok && slot_valid[i] && slot_base[i] == op.query) begin
                        slot_valid[i] = 0;
                        r.ok = 1;
                    end
            end
            default: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_valid[i] && slot_base[i] <= op.query &&
                        (best < 0 || slot_base[i] > slot_base[best]))
                        best = i;
                if (best >= 0) begin
                    off = op.query - slot_base[best];
                    if ({24'b0, off} < {31'b0, slot_bytes[best]}) begin
                        r.gpu_addr = slot_base[best];
                        r.ok = 1;
                        r.guest = slot_guest[best] + {24'b0, off};
                        r.size = slot_bytes[best];
                        r.handle = slot_handle[best];
                        r.flags = slot_flags[best];
                        r.page = slot_page[best];
                    end
                end
            end
        endcase
    endtask

    task automatic send_op(input op_t op);
        xlat_t r;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid             <= 1;
        s_func              <= op.func;
        s_page_count        <= op.pages;
        s_page_bytes        <= op.pbytes;
        s_fixed_addr        <= op.fixed;
        s_buffer_handle     <= op.handle;
        s_map_flag_bits     <= op.flags;
        s_buffer_found      <= op.found;
        s_buffer_bytes      <= op.bbytes;
        s_buffer_guest_addr <= op.gaddr;
        s_query_addr        <= op.query;
        do @(posedge aclk); while (!s_ready);
        predict_mapper(op, r);
        pending_xlats.push_back(r);
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 0;
        else if (hold_left > 0)
            m_ready <= 0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(negedge aclk)
        if (hold_left > 0)
            hold_left = hold_left - 1;

    always @(posedge aclk) begin
        xlat_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_xlats.size() == 0) begin
                report_mismatch("unexpected_beat", {24'b0, m_gpu_addr}, 64'd0);
            end else begin
                w = pending_xlats.pop_front();
                if (m_gpu_addr !== w.gpu_addr)
                    report_mismatch("gpu_addr", m_gpu_addr, w.gpu_addr);
                if (m_ok !== w.ok)
                    report_mismatch("ok", m_ok, w.ok);
                if (m_guest_addr !== w.guest)
                    report_mismatch("guest_addr", m_guest_addr, w.guest);
                if (m_entry_size !== w.size)
                    report_mismatch("entry_size", m_entry_size, w.size);
                if (m_entry_handle !== w.handle)
                    report_mismatch("entry_handle", m_entry_handle, w.handle);
                if (m_entry_flags !== w.flags)
                    report_mismatch("entry_flags", m_entry_flags, w.flags);
                if (m_entry_page_bytes !== w.page)
                    report_mismatch("entry_page_bytes", m_entry_page_bytes, w.page);
            end
        end
    end

    task automatic drain;
        s_valid <= 0;
        while (pending_xlats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_va_start(input logic [39:0] v);
        drain();
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= REG_VA_REGION_START;
        pwdata  <= {24'b0, v};
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        va_start = v;
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge aclk);
    endtask

    function automatic op_t blank_op(input func_t f);
        op_t op;
        op = '0;
        op.func = f;
        return op;
    endfunction

    function automatic int random_live_slot();
        int live[$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_valid[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(live.size() - 1)];
    endfunction

    function automatic op_t random_op();
        op_t op;
        int s, pick;
        op.func   = func_t'($urandom_range(3));
        op.pages  = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(16));
        op.pbytes = ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(4) * 4096);
        op.fixed  = ($urandom_range(7) == 0) ? {8'($urandom), 32'($urandom)} : '0;
        op.handle = $urandom;
        op.flags  = $urandom;
        op.found  = ($urandom_range(9) != 0);
        op.bbytes = ($urandom_range(7) == 0) ? $urandom : $urandom_range(200000);
        op.gaddr  = {$urandom, $urandom};
        op.query  = {8'($urandom), 32'($urandom)};
        pick = $urandom_range(99);
        op.func = pick < 15 ? FUNC_ALLOC : pick < 50 ? FUNC_MAP :
                  pick < 70 ? FUNC_UNMAP : FUNC_LOOKUP;
        s = random_live_slot();
        if (s >= 0) begin
            if (op.func == FUNC_MAP && $urandom_range(9) == 0)
                op.fixed = slot_base[s];
            if (op.func == FUNC_UNMAP && $urandom_range(4) != 0)
                op.query = slot_base[s];
            if (op.func == FUNC_LOOKUP && $urandom_range(4) != 0)
                op.query = slot_base[s]
                           + 40'($urandom_range(32'(slot_bytes[s] + 33'd16)));
        end
        return op;
    endfunction

    task automatic test_directed;
        op_t op;
        logic [39:0] b;
        op = blank_op(FUNC_ALLOC);
        send_op(op);
        op.pages = '1; op.pbytes = '1;
        send_op(op);
        op.pages = 20'd3; op.pbytes = 18'd131072; op.fixed = '1;
        send_op(op);
        op = blank_op(FUNC_MAP);
        op.bbytes = 32'd5000; op.handle = '1; op.flags = '1;
        send_op(op);
        op.found = 1;
        send_op(op);
        b = last_mapped;
        op = blank_op(FUNC_MAP);
        op.found = 1; op.bbytes = '1; op.gaddr = '1; op.pbytes = '1;
        op.handle = 32'hA5A5_5A5A; op.flags = 32'h5A5A_A5A5;
        send_op(op);
        op.found = 1; op.bbytes = '0; op.fixed = 40'h12_3456_7000;
        send_op(op);
        op.bbytes = 32'd8192; op.handle = 32'h1;
        send_op(op);
        op = blank_op(FUNC_LOOKUP);
        op.query = b;
        send_op(op);
        op.query = b + 40'd8191;
        send_op(op);
        op.query = b + 40'd8192;
        send_op(op);
        op.query = last_mapped + 40'h1fff_f000;
        send_op(op);
        op.query = '0;
        send_op(op);
        op.query = '1;
        send_op(op);
        op.query = 40'h12_3456_7fff;
        send_op(op);
        op = blank_op(FUNC_UNMAP);
        op.query = b;
        send_op(op);
        send_op(op);
        op.query = '1;
        send_op(op);
        op = blank_op(FUNC_LOOKUP);
        op.query = b + 40'd16;
        send_op(op);
    endtask

    task automatic test_table_full;
        op_t op;
        int free_slots;
        free_slots = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!slot_valid[i])
                free_slots++;
        for (int n = 0; n < free_slots + 3; n++) begin
            op = random_op();
            op.func = FUNC_MAP;
            op.found = 1;
            op.fixed = '0;
            send_op(op);
        end
        op.fixed = slot_base[random_live_slot()];
        send_op(op);
        for (int n = 0; n < NUM_SLOTS / 2; n++) begin
            op = blank_op(FUNC_UNMAP);
            op.query = slot_base[random_live_slot()];
            send_op(op);
        end
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++)
            send_op(random_op());
    endtask

    task automatic test_backpressure;
        op_t op;
        send_idle_pct = 0;
        @(negedge aclk);
        hold_left = 400;
        for (int n = 0; n < 12; n++) begin
            op = random_op();
            op.func = (n % 2) ? FUNC_LOOKUP : FUNC_ALLOC;
            send_op(op);
        end
    endtask

    initial begin
        va_start = '0;
        bump_ofs = '0;
        last_mapped = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_valid[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        write_va_start({8'($urandom), 32'($urandom)});
        test_table_full();
        test_random(125, 25, 71);
        write_va_start('1);
        test_random(125, 71, 25);
        write_va_start('0);
        test_backpressure();
        write_va_start({8'($urandom), 32'($urandom)});
        test_random(125, 0, 0);
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
